// ----- src/tce_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants and types for the transitive closure engine.
// No dependencies; every other file in src uses this package.
package tce_pkg;

    localparam int MAX_NODES_DEF = 16;

    localparam int KIND_W    = 2;
    localparam int NODE_W    = 4;
    localparam int COUNT_W   = 5;
    localparam int ROW_OUT_W = 16;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 24;

    localparam logic [COUNT_W-1:0] NODE_COUNT_RST = COUNT_W'(16);

    localparam logic [KIND_W-1:0] KIND_ADD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CLOSE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    // Per-cycle commands from the sequencer to every row cell.
    typedef struct packed {
        logic clear;
        logic add;
        logic shift;
        logic update;
    } cell_ctl_t;

endpackage

// ----- src/tce_cell.sv -----
`timescale 1ns / 1ps
// One row cell of the ring: holds one matrix row and the number of that row.
// Depends on tce_pkg.
module tce_cell #(
    parameter int MAX_NODES = tce_pkg::MAX_NODES_DEF,
    parameter int POS       = 0
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  tce_pkg::cell_ctl_t                  ctl,
    input  logic [tce_pkg::NODE_W-1:0]          src_node,
    input  logic [tce_pkg::NODE_W-1:0]          dst_node,
    input  logic [$clog2(MAX_NODES)-1:0]        k_idx,
    input  logic [MAX_NODES-1:0]                krow,
    input  logic [((($clog2(MAX_NODES+1)) > tce_pkg::COUNT_W) ?
                   $clog2(MAX_NODES+1) : tce_pkg::COUNT_W)-1:0] n_eff,
    input  logic [MAX_NODES-1:0]                nb_row,
    input  logic [$clog2(MAX_NODES)-1:0]        nb_id,
    output logic [MAX_NODES-1:0]                row_q,
    output logic [MAX_NODES-1:0]                row_upd,
    output logic [$clog2(MAX_NODES)-1:0]        id_q
);

    localparam int IDW = $clog2(MAX_NODES);
    localparam int CW  = ($clog2(MAX_NODES+1) > tce_pkg::COUNT_W) ?
                         $clog2(MAX_NODES+1) : tce_pkg::COUNT_W;

    logic [MAX_NODES-1:0] row_reg, row_next;
    logic [IDW-1:0]       id_reg, id_next;
    logic [MAX_NODES-1:0] dst_bit;
    logic                 hit;

    // Row i picks up row k when it reaches k and is one of the nodes in use.
    assign hit     = ctl.update && row_reg[k_idx] && (CW'(id_reg) < n_eff);
    assign row_upd = hit ? (row_reg | krow) : row_reg;
    assign row_q   = row_reg;
    assign id_q    = id_reg;

    always_comb
    begin
        for (int b = 0; b < MAX_NODES; b++)
        begin
            dst_bit[b] = (int'(dst_node) == b);
        end
    end

    always_comb
    begin
        row_next = row_reg;
        id_next  = id_reg;
        if (ctl.clear)
        begin
            row_next = '0;
        end
        else if (ctl.add && (int'(src_node) == POS))
        begin
            row_next = row_reg | dst_bit;
        end
        else if (ctl.shift)
        begin
            row_next = nb_row;
            id_next  = nb_id;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            id_reg  <= IDW'(POS);
        end
        else
        begin
            row_reg <= row_next;
            id_reg  <= id_next;
        end
    end

endmodule

// ----- src/tce_seq.sv -----
`timescale 1ns / 1ps
// Sequencer: decodes input beats, steps the closure and emit passes around the ring.
// Depends on tce_pkg.
module tce_seq #(
    parameter int MAX_NODES = tce_pkg::MAX_NODES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [tce_pkg::KIND_W-1:0]          kind,
    input  logic [tce_pkg::NODE_W-1:0]          src_node,
    input  logic [tce_pkg::NODE_W-1:0]          dst_node,
    input  logic [((($clog2(MAX_NODES+1)) > tce_pkg::COUNT_W) ?
                   $clog2(MAX_NODES+1) : tce_pkg::COUNT_W)-1:0] n_eff,
    input  logic                                slot_free,
    output tce_pkg::cell_ctl_t                  ctl,
    output logic [$clog2(MAX_NODES)-1:0]        step,
    output logic                                emit,
    output logic                                last
);

    localparam int IDW = $clog2(MAX_NODES);
    localparam int CW  = ($clog2(MAX_NODES+1) > tce_pkg::COUNT_W) ?
                         $clog2(MAX_NODES+1) : tce_pkg::COUNT_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CLOSE = 2'd1;
    localparam logic [1:0] ST_EMIT  = 2'd2;

    localparam logic [IDW-1:0] STEP_LAST = IDW'(MAX_NODES - 1);

    logic [1:0]     state_reg, state_next;
    logic [IDW-1:0] step_reg, step_next;
    logic           accept;
    logic           in_use;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign step     = step_reg;
    assign in_use   = (CW'(step_reg) < n_eff);
    assign emit     = (state_reg == ST_EMIT) && in_use;
    assign last     = ((CW'(step_reg) + CW'(1)) == n_eff);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        ctl        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (kind)
                        tce_pkg::KIND_ADD:
                        begin
                            ctl.add = (CW'(src_node) < n_eff) && (CW'(dst_node) < n_eff);
                        end
                        tce_pkg::KIND_CLEAR:
                        begin
                            ctl.clear = 1'b1;
                        end
                        tce_pkg::KIND_CLOSE:
                        begin
                            state_next = ST_CLOSE;
                            step_next  = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_CLOSE:
            begin
                ctl.shift  = 1'b1;
                ctl.update = in_use;
                step_next  = step_reg + IDW'(1);
                if (step_reg == STEP_LAST)
                begin
                    state_next = ST_EMIT;
                    step_next  = '0;
                end
            end
            ST_EMIT:
            begin
                if (!emit || slot_free)
                begin
                    ctl.shift = 1'b1;
                    step_next = step_reg + IDW'(1);
                    if (step_reg == STEP_LAST)
                    begin
                        state_next = ST_IDLE;
                        step_next  = '0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

// ----- src/transitive_closure_engine.sv -----
`timescale 1ns / 1ps
// Transitive closure engine: a ring of row cells with a sequencer and an output register.
// Depends on tce_pkg, tce_cell and tce_seq.
//
// Usage. Input beats arrive on s_tvalid/s_tready. s_tuser carries the kind: add edge,
// compute closure, or clear. s_tdata carries src_node and dst_node for an added edge.
// Add-edge and clear beats take effect in the cycle they are accepted, so they stream
// in at one beat per cycle with no result. An edge that names a node at or above the
// node count is dropped.
// A compute beat runs Warshall's closure in place and then streams one beat per row on
// m_tvalid/m_tready, rows 0 to node_count-1, with m_tlast on the final row.
// The matrix rows rotate around the ring of MAX_NODES cells, one position per cycle
// unless the receiver stalls, once for the closure pass (row k sits at the head in step k
// and is broadcast to every cell) and once for the emit pass, so a compute beat occupies
// the block until both passes are done. The first row goes out through the output
// register once the emit pass starts.
// When the receiver stalls, the emit pass holds the ring in place until the output
// register drains; no input beat is taken until the rotation has come full circle.
// Reset clears the matrix and sets node_count to 16. The node count is written on the
// cfg channel, which is always ready and must be used only while the block is idle.
module transitive_closure_engine #(
    parameter int MAX_NODES = tce_pkg::MAX_NODES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Configuration: node_count.
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tce_pkg::COUNT_W-1:0]        cfg_data,
    // Input beats.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [tce_pkg::S_TDATA_W-1:0]      s_tdata,   // [3:0] src_node, [7:4] dst_node
    input  logic [tce_pkg::KIND_W-1:0]         s_tuser,   // [1:0] kind
    // Result beats.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [tce_pkg::M_TDATA_W-1:0]      m_tdata,   // [3:0] row_index, [19:4] reach_row
    output logic                               m_tlast    // last_row
);

    localparam int IDW = $clog2(MAX_NODES);
    localparam int CW  = ($clog2(MAX_NODES+1) > tce_pkg::COUNT_W) ?
                         $clog2(MAX_NODES+1) : tce_pkg::COUNT_W;

    logic [tce_pkg::COUNT_W-1:0]   node_count_reg;
    logic [CW-1:0]                 count_ext;
    logic [CW-1:0]                 n_eff;
    logic [MAX_NODES-1:0]          use_mask;
    logic [MAX_NODES-1:0]          krow;

    tce_pkg::cell_ctl_t            ctl;
    logic [IDW-1:0]                step;
    logic                          emit;
    logic                          last;
    logic                          slot_free;

    logic [MAX_NODES-1:0]          row_q   [MAX_NODES];
    logic [MAX_NODES-1:0]          row_upd [MAX_NODES];
    logic [IDW-1:0]                id_q    [MAX_NODES];

    logic [tce_pkg::NODE_W-1:0]    src_node;
    logic [tce_pkg::NODE_W-1:0]    dst_node;
    logic [tce_pkg::ROW_OUT_W-1:0] head_row;
    logic [tce_pkg::NODE_W-1:0]    head_index;

    logic                          out_valid_reg;
    logic [tce_pkg::NODE_W-1:0]    out_index_reg;
    logic [tce_pkg::ROW_OUT_W-1:0] out_row_reg;
    logic                          out_last_reg;

    assign src_node = s_tdata[tce_pkg::NODE_W-1:0];
    assign dst_node = s_tdata[2*tce_pkg::NODE_W-1:tce_pkg::NODE_W];

    // Node count register; values above the ring size act as the ring size.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= tce_pkg::NODE_COUNT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            node_count_reg <= cfg_data;
        end
    end

    assign count_ext = CW'(node_count_reg);
    assign n_eff     = (count_ext > CW'(MAX_NODES)) ? CW'(MAX_NODES) : count_ext;

    always_comb
    begin
        for (int b = 0; b < MAX_NODES; b++)
        begin
            use_mask[b] = (CW'(b) < n_eff);
        end
    end

    // The row at the head of the ring is row k during the closure pass.
    assign krow = row_q[0] & use_mask;

    tce_seq #(
        .MAX_NODES (MAX_NODES)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .kind      (s_tuser),
        .src_node  (src_node),
        .dst_node  (dst_node),
        .n_eff     (n_eff),
        .slot_free (slot_free),
        .ctl       (ctl),
        .step      (step),
        .emit      (emit),
        .last      (last)
    );

    // Each cell takes the (possibly updated) row of its upper neighbor, closing a ring.
    for (genvar c = 0; c < MAX_NODES; c++)
    begin : g_cell
        tce_cell #(
            .MAX_NODES (MAX_NODES),
            .POS       (c)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .src_node (src_node),
            .dst_node (dst_node),
            .k_idx    (step),
            .krow     (krow),
            .n_eff    (n_eff),
            .nb_row   (row_upd[(c + 1) % MAX_NODES]),
            .nb_id    (id_q[(c + 1) % MAX_NODES]),
            .row_q    (row_q[c]),
            .row_upd  (row_upd[c]),
            .id_q     (id_q[c])
        );
    end

    // During the emit pass the head cell holds row number step.
    assign head_row   = tce_pkg::ROW_OUT_W'(64'(krow));
    assign head_index = tce_pkg::NODE_W'(32'(step));

    assign slot_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit && slot_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit && slot_free)
        begin
            out_index_reg <= head_index;
            out_row_reg   <= head_row;
            out_last_reg  <= last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_row_reg, out_index_reg};
    assign m_tlast  = out_last_reg;

endmodule

// ----- dv/transitive_closure_engine_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for transitive_closure_engine: edge, clear and closure beats are
// checked row by row against a reachability predictor kept in this file. Depends on tce_pkg.
module transitive_closure_engine_test;

    localparam int KIND_W    = tce_pkg::KIND_W;
    localparam int NODE_W    = tce_pkg::NODE_W;
    localparam int COUNT_W   = tce_pkg::COUNT_W;
    localparam int ROW_OUT_W = tce_pkg::ROW_OUT_W;
    localparam int S_TDATA_W = tce_pkg::S_TDATA_W;
    localparam int M_TDATA_W = tce_pkg::M_TDATA_W;

    localparam int NODES      = tce_pkg::MAX_NODES_DEF;
    // A compute beat keeps the block busy for two turns of the row ring.
    localparam int BUSY_CYCLES = 2 * NODES + 8;
    localparam int QUIET_LIMIT = 2000;
    localparam int MAX_REPORTS = 10;

    // Kind code that the block does not define; it must be ignored.
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [NODE_W-1:0]    row_index;
        logic [ROW_OUT_W-1:0] reach_row;
        logic                 last_row;
    } row_beat_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [COUNT_W-1:0]   cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // [3:0] src_node, [7:4] dst_node
    logic [KIND_W-1:0]    s_tuser;   // [1:0] kind
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;   // [3:0] row_index, [19:4] reach_row
    logic                 m_tlast;   // last_row

    // Predictor state: the edge matrix and the node count as the block should hold them.
    logic [ROW_OUT_W-1:0] reach_rows [NODES];
    logic [COUNT_W-1:0]   node_count_now;
    row_beat_t            expected_rows [$];

    int mismatch_count;
    int quiet_cycles;
    int send_idle_pct;
    int recv_idle_pct;

    transitive_closure_engine dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Node counts above the matrix size behave as the full matrix.
    function automatic int unsigned active_nodes();
        int unsigned n;
        n = node_count_now;
        if (n > NODES)
            n = NODES;
        return n;
    endfunction

    // Warshall's pass over the rows in use, then one expected beat per row. Rows and
    // columns beyond the node count keep their bits but stay out of the pass and the output.
    task automatic close_and_queue_rows();
        int unsigned          n;
        logic [NODES:0]       wide_mask;
        logic [ROW_OUT_W-1:0] mask;
        logic [ROW_OUT_W-1:0] pivot_row;
        row_beat_t            beat;
        n = active_nodes();
        wide_mask = (17'd1 << n) - 17'd1;
        mask = wide_mask[ROW_OUT_W-1:0];
        for (int k = 0; k < n; k++)
        begin
            pivot_row = reach_rows[k] & mask;
            for (int i = 0; i < n; i++)
                if (reach_rows[i][k])
                    reach_rows[i] = reach_rows[i] | pivot_row;
        end
        for (int i = 0; i < n; i++)
        begin
            beat.row_index = NODE_W'(i);
            beat.reach_row = reach_rows[i] & mask;
            beat.last_row  = (i + 1 == n);
            expected_rows.insert(expected_rows.size(), beat);
        end
    endtask

    task automatic predict_beat(logic [KIND_W-1:0] kind, logic [NODE_W-1:0] src,
                                logic [NODE_W-1:0] dst);
        int unsigned n;
        n = active_nodes();
        case (kind)
            tce_pkg::KIND_ADD:
            begin
                // An edge touching a node outside the count is dropped.
                if (src < n && dst < n)
                    reach_rows[src][dst] = 1'b1;
            end
            tce_pkg::KIND_CLEAR:
            begin
                for (int i = 0; i < NODES; i++)
                    reach_rows[i] = '0;
            end
            tce_pkg::KIND_CLOSE:
                close_and_queue_rows();
            default:
            begin
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Result checking, receiver stalls and watchdog
    // ------------------------------------------------------------------

    task automatic note_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("MISMATCH at %0t ns: %s", $realtime, what);
    endtask

    // Checks use the ready value that was on the wire at this edge, then pick the next one.
    always @(posedge clk)
    begin
        row_beat_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_rows.size() == 0)
                note_mismatch($sformatf("unexpected row beat tdata=%h tlast=%b",
                                        m_tdata, m_tlast));
            else
            begin
                want = expected_rows.pop_front();
                if (m_tdata[NODE_W-1:0] !== want.row_index)
                    note_mismatch($sformatf("row_index expected %0d got %0d",
                                            want.row_index, m_tdata[NODE_W-1:0]));
                if (m_tdata[NODE_W +: ROW_OUT_W] !== want.reach_row)
                    note_mismatch($sformatf("row %0d reach_row expected %h got %h",
                                            want.row_index, want.reach_row,
                                            m_tdata[NODE_W +: ROW_OUT_W]));
                if (m_tlast !== want.last_row)
                    note_mismatch($sformatf("row %0d last_row expected %b got %b",
                                            want.row_index, want.last_row, m_tlast));
            end
        end
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Any beat on any channel counts as progress; a long silence means the block hung.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Shared drivers
    // ------------------------------------------------------------------

    // Offers one input beat, idling first at the current rate. Valid is left high so that
    // back-to-back beats never lower and raise it in the same step.
    task automatic send_beat(logic [KIND_W-1:0] kind, logic [NODE_W-1:0] src,
                             logic [NODE_W-1:0] dst);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {dst, src};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_beat(kind, src, dst);
    endtask

    // Holds the input side idle until every queued row has come back.
    task automatic wait_for_rows();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_rows.size() != 0)
            @(posedge clk);
    endtask

    // A closure with no rows can still be running, so the block gets its full busy time
    // before the count changes.
    task automatic write_node_count(logic [COUNT_W-1:0] value);
        wait_for_rows();
        repeat (BUSY_CYCLES)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        node_count_now = value;
    endtask

    function automatic logic [NODE_W-1:0] node_in_use();
        int unsigned n;
        n = active_nodes();
        if (n == 0)
            return NODE_W'($urandom_range(NODES - 1));
        return NODE_W'($urandom_range(n - 1));
    endfunction

    // Mostly ordinary counts, now and then a boundary or out-of-range value.
    function automatic logic [COUNT_W-1:0] pick_node_count();
        case ($urandom_range(11))
            0:       return COUNT_W'(0);
            1:       return COUNT_W'(1);
            2:       return COUNT_W'(NODES);
            3:       return COUNT_W'($urandom_range(31, NODES + 1));
            default: return COUNT_W'($urandom_range(NODES, 2));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Right after reset the matrix is empty and the count is the full matrix.
    task automatic test_reset_state();
        send_beat(tce_pkg::KIND_CLOSE, 4'd0, 4'd0);
    endtask

    // A chain through the corner nodes, a self loop and a back edge, so the closure has
    // to chain several pivots; then clear and close again to see an empty matrix.
    task automatic test_chain_and_clear();
        send_beat(tce_pkg::KIND_ADD, 4'd0, 4'd15);
        send_beat(tce_pkg::KIND_ADD, 4'd15, 4'd3);
        send_beat(tce_pkg::KIND_ADD, 4'd3, 4'd9);
        send_beat(tce_pkg::KIND_ADD, 4'd7, 4'd7);
        send_beat(tce_pkg::KIND_ADD, 4'd9, 4'd0);
        send_beat(tce_pkg::KIND_CLOSE, 4'd15, 4'd15);
        send_beat(tce_pkg::KIND_CLEAR, 4'd5, 4'd10);
        send_beat(tce_pkg::KIND_CLOSE, 4'd0, 4'd0);
    endtask

    // With four nodes in use, edges that leave the set and the unused kind change nothing.
    // Bits stored earlier outside the set must survive and show up again at full count.
    task automatic test_small_count_and_ignored();
        send_beat(tce_pkg::KIND_ADD, 4'd12, 4'd14);
        write_node_count(COUNT_W'(4));
        send_beat(tce_pkg::KIND_ADD, 4'd5, 4'd1);
        send_beat(tce_pkg::KIND_ADD, 4'd1, 4'd15);
        send_beat(KIND_UNUSED, 4'd3, 4'd2);
        send_beat(tce_pkg::KIND_ADD, 4'd3, 4'd0);
        send_beat(tce_pkg::KIND_ADD, 4'd0, 4'd3);
        send_beat(tce_pkg::KIND_CLOSE, 4'd0, 4'd0);
        write_node_count(COUNT_W'(NODES));
        send_beat(tce_pkg::KIND_CLOSE, 4'd0, 4'd0);
    endtask

    // Count of zero yields no rows, a count of one yields a single last row, and counts
    // above the matrix size act as the full matrix.
    task automatic test_count_extremes();
        write_node_count(COUNT_W'(0));
        send_beat(tce_pkg::KIND_ADD, 4'd0, 4'd0);
        send_beat(tce_pkg::KIND_CLOSE, 4'd0, 4'd0);
        write_node_count(COUNT_W'(1));
        send_beat(tce_pkg::KIND_CLEAR, 4'd0, 4'd0);
        send_beat(tce_pkg::KIND_ADD, 4'd0, 4'd0);
        send_beat(tce_pkg::KIND_CLOSE, 4'd0, 4'd0);
        write_node_count(COUNT_W'(31));
        send_beat(tce_pkg::KIND_ADD, 4'd14, 4'd2);
        send_beat(tce_pkg::KIND_CLOSE, 4'd0, 4'd0);
        write_node_count(COUNT_W'(NODES + 1));
        send_beat(tce_pkg::KIND_CLOSE, 4'd0, 4'd0);
    endtask

    // Random graphs: mostly a run of in-range edges ended by a closure, sometimes after a
    // clear, mixed with stray beats of any kind and field values. Once, halfway through,
    // the sender waits for every outstanding row.
    task automatic test_random_graphs(int beats);
        int  sent;
        int  edges;
        bit  paused;
        sent   = 0;
        paused = 0;
        write_node_count(pick_node_count());
        while (sent < beats)
        begin
            if ($urandom_range(15) == 0)
                write_node_count(pick_node_count());
            if (!paused && sent >= beats / 2)
            begin
                wait_for_rows();
                paused = 1;
            end
            if ($urandom_range(9) < 7)
            begin
                if ($urandom_range(3) == 0)
                begin
                    send_beat(tce_pkg::KIND_CLEAR, NODE_W'($urandom), NODE_W'($urandom));
                    sent++;
                end
                edges = $urandom_range(10, 1);
                repeat (edges)
                    send_beat(tce_pkg::KIND_ADD, node_in_use(), node_in_use());
                send_beat(tce_pkg::KIND_CLOSE, NODE_W'($urandom), NODE_W'($urandom));
                sent += edges + 1;
            end
            else
            begin
                send_beat(KIND_W'($urandom_range(3)), NODE_W'($urandom), NODE_W'($urandom));
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = tce_pkg::KIND_ADD;
        m_tready       = 1'b0;
        mismatch_count = 0;
        quiet_cycles   = 0;
        send_idle_pct  = 19;
        recv_idle_pct  = 88;
        node_count_now = tce_pkg::NODE_COUNT_RST;
        for (int i = 0; i < NODES; i++)
            reach_rows[i] = '0;

        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_chain_and_clear();
        test_small_count_and_ignored();
        test_count_extremes();

        test_random_graphs(130);
        send_idle_pct = 88;
        recv_idle_pct = 19;
        test_random_graphs(130);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_graphs(140);

        wait_for_rows();
        repeat (BUSY_CYCLES)
            @(posedge clk);

        if (mismatch_count == 0 && expected_rows.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
